// ===== hw/rtl/bnm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bnm_pkg
// Shared types and constants of the barcode nearest-match classifier.
// ----------------------------------------------------------------------------
package bnm_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_ENTRIES_DEF    = 16;
	localparam int MAX_CODE_CHARS_DEF = 8;

	// Fixed field widths.
	localparam int OP_W       = 1;
	localparam int SLOT_W     = 4;
	localparam int CHARS_W    = 64;
	localparam int TOL_W      = 4;
	localparam int COUNT_W    = 4;
	localparam int CODE_LEN_W = 4;
	localparam int ENTRY_CNT_W = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CODE_LEN_W-1:0]  CODE_LEN_RESET  = 4'd6;
	localparam logic [ENTRY_CNT_W-1:0] ENTRY_CNT_RESET = 5'd0;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_LENGTH = 1'b0,
		CFG_ENTRY_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage : bnm_pkg
`default_nettype wire

// ===== hw/rtl/bnm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bnm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : bnm_ram
`default_nettype wire

// ===== hw/rtl/barcode_nearest_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// barcode_nearest_match
// Assigns a read's index characters to the nearest sample barcode of a table.
//
// The block holds MAX_ENTRIES sample barcodes, each with its own mismatch
// tolerance, in one RAM with a registered read port. A load beat
// (op = 0) writes one entry and returns an all-zero result: it is
// accepted, then its result is placed. A classify beat (op = 1) compares
// the read against the entries in use, slots 0 upward, where the number
// in use is entry_count capped at MAX_ENTRIES. It reads one entry per
// cycle through the single RAM read port and counts byte mismatches over
// the first code_length characters (capped at MAX_CODE_CHARS). Its steps
// are accept, one read per entry, retiring the last read and placing the
// result; with no entry in use it goes from accept straight to placing
// the result. The read is assigned when exactly one entry reaches the
// smallest count and that count is within the entry's tolerance;
// otherwise assigned and sample are zero. best_mismatches reports the
// smallest count, or the capped code_length + 1 when no entry is in use.
// One beat is processed at a time, but a new beat is taken while the
// previous result still waits in the output register. Entries that were
// never loaded hold unknown data and must not be classified against.
// Configuration writes are only legal while the block is idle.
// ----------------------------------------------------------------------------
module barcode_nearest_match
	import bnm_pkg::*;
#(
	parameter int MAX_ENTRIES    = MAX_ENTRIES_DEF,
	parameter int MAX_CODE_CHARS = MAX_CODE_CHARS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [SLOT_W-1:0]     slot,
	input  wire logic [CHARS_W-1:0]    sequence_chars,
	input  wire logic [TOL_W-1:0]      tolerance,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       assigned,
	output logic [SLOT_W-1:0]          sample,
	output logic [COUNT_W-1:0]         best_mismatches
);

	// Address width of the table, and a counter width that can hold the
	// number of entries itself.
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	// Only the characters that can ever be compared are stored.
	localparam int DW = 8 * MAX_CODE_CHARS;
	localparam int RW = DW + TOL_W;

	// Configuration registers.
	logic [CODE_LEN_W-1:0]  cfg_code_length_q;
	logic [ENTRY_CNT_W-1:0] cfg_entry_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_code_length_q <= CODE_LEN_RESET;
			cfg_entry_count_q <= ENTRY_CNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODE_LENGTH: cfg_code_length_q <= cfg_data[CODE_LEN_W-1:0];
				CFG_ENTRY_COUNT: cfg_entry_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturated length and entry count.
	logic [CODE_LEN_W-1:0] len_sat;
	logic [CW-1:0]         used_sat;

	always_comb begin
		if (cfg_code_length_q > 4'(MAX_CODE_CHARS)) begin
			len_sat = 4'(MAX_CODE_CHARS);
		end else begin
			len_sat = cfg_code_length_q;
		end
		if (int'(cfg_entry_count_q) > MAX_ENTRIES) begin
			used_sat = CW'(MAX_ENTRIES);
		end else begin
			used_sat = CW'(cfg_entry_count_q);
		end
	end

	// Control state and the accepted beat.
	state_t         state_q, state_d;
	logic           op_q;
	logic [DW-1:0]  chars_q;
	logic [CW-1:0]  scan_cnt_q, scan_cnt_d;
	logic           in_fire;
	logic           out_fire;
	logic           out_free;
	logic           scan_last;
	logic           emit;

	// Running search result.
	logic [COUNT_W-1:0] best_q;
	logic [AW-1:0]      best_slot_q;
	logic [TOL_W-1:0]   best_tol_q;
	logic               found_q;
	logic               tie_q;

	// Table RAM interface.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic          ram_re;
	logic [RW-1:0] ram_rdata;
	logic          slot_in_range;
	logic [AW+SLOT_W-1:0] slot_ext;

	// Read pipeline stage: the entry whose data the RAM presents now.
	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;

	// Output register.
	logic                out_valid_q;
	logic                assigned_q;
	logic [SLOT_W-1:0]   sample_q;
	logic [COUNT_W-1:0]  best_mis_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_last = ((scan_cnt_q + CW'(1)) == used_sat);
	assign emit      = (state_q == ST_EMIT) && out_free;

	// Loads write the RAM straight from the accepted beat. A scan starts no
	// earlier than the next cycle, so a read never overlaps a write to the
	// same entry and no forwarding is needed.
	assign slot_ext      = {{AW{1'b0}}, slot};
	assign slot_in_range = (int'(slot) < MAX_ENTRIES);
	assign ram_we        = in_fire && (op == OP_LOAD) && slot_in_range;
	assign ram_waddr     = slot_ext[AW-1:0];
	assign ram_wdata     = {tolerance, sequence_chars[DW-1:0]};
	assign ram_re        = (state_q == ST_SCAN);

	bnm_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Sequencer: idle, one read issued per entry, retire the last read,
	// then place the result in the output register.
	always_comb begin
		state_d    = state_q;
		scan_cnt_d = scan_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					scan_cnt_d = '0;
					if ((op == OP_CLASSIFY) && (used_sat != '0)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end else begin
					scan_cnt_d = scan_cnt_q + CW'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_cnt_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_cnt_q  <= scan_cnt_d;
			rd_valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q[AW-1:0];
		if (in_fire) begin
			op_q    <= op;
			chars_q <= sequence_chars[DW-1:0];
		end
	end

	// Mismatch count of the entry presented by the RAM, over the active
	// characters only.
	logic [COUNT_W-1:0] mism_cnt;
	logic [DW-1:0]      rd_code;
	logic [TOL_W-1:0]   rd_tol;

	assign rd_code = ram_rdata[DW-1:0];
	assign rd_tol  = ram_rdata[DW +: TOL_W];

	always_comb begin
		mism_cnt = '0;
		for (int i = 0; i < MAX_CODE_CHARS; i++) begin
			if ((4'(i) < len_sat) && (chars_q[8*i +: 8] != rd_code[8*i +: 8])) begin
				mism_cnt = mism_cnt + COUNT_W'(1);
			end
		end
	end

	// Running minimum. A strictly smaller count takes over and clears the
	// tie; an equal count marks a tie on the current minimum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			tie_q   <= 1'b0;
		end else if (in_fire) begin
			found_q <= 1'b0;
			tie_q   <= 1'b0;
		end else if (rd_valid_s1) begin
			if (mism_cnt < best_q) begin
				found_q <= 1'b1;
				tie_q   <= 1'b0;
			end else if (mism_cnt == best_q) begin
				tie_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			best_q <= len_sat + COUNT_W'(1);
		end else if (rd_valid_s1 && (mism_cnt < best_q)) begin
			best_q      <= mism_cnt;
			best_slot_q <= rd_idx_s1;
			best_tol_q  <= rd_tol;
		end
	end

	// Final decision and the output register.
	logic                 win;
	logic [AW+SLOT_W-1:0] best_slot_ext;

	assign best_slot_ext = {{SLOT_W{1'b0}}, best_slot_q};
	assign win = found_q && !tie_q && (best_q <= best_tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (op_q == OP_LOAD) begin
				assigned_q <= 1'b0;
				sample_q   <= '0;
				best_mis_q <= '0;
			end else begin
				assigned_q <= win;
				sample_q   <= win ? best_slot_ext[SLOT_W-1:0] : '0;
				best_mis_q <= best_q;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign assigned        = assigned_q;
	assign sample          = sample_q;
	assign best_mismatches = best_mis_q;

	// Read data is only consumed in the cycle after a read was issued.
	a_rd_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ST_SCAN))
		else $error("read data retired without a preceding read");

	// The last read is still in flight while the sequencer retires it.
	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> rd_valid_s1)
		else $error("drain cycle without read data");

	// An unassigned result reports sample zero.
	a_unassigned_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !assigned) |-> (sample == '0))
		else $error("unassigned result carries a sample");

	// An assigned read has a count within the compared length.
	a_assigned_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && assigned) |-> (best_mismatches <= len_sat))
		else $error("assigned result with count beyond the code length");

endmodule : barcode_nearest_match
`default_nettype wire
